// ----- rtl/c5rm_pkg.sv -----
`default_nettype none
package c5rm_pkg;

   localparam int IMAGE_SIZE  = 32;
   localparam int KERNEL_SIZE = 5;
   localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
   localparam int CONV_SIZE   = IMAGE_SIZE - KERNEL_SIZE + 1;
   localparam int POOL_SIZE   = CONV_SIZE / 2;
   localparam int COL_W       = $clog2(IMAGE_SIZE);
   localparam int POS_W       = $clog2(POOL_SIZE + 1);
   localparam int LINE_W      = (KERNEL_SIZE - 1) * 8;
   localparam int PROD_W      = 25;
   localparam int ROW_W       = PROD_W + $clog2(KERNEL_SIZE);
   localparam int SUM_W       = PROD_W + $clog2(TAPS);
   localparam int VALUE_W     = 28;
   localparam int VALUE_MAX   = 268435455;
   localparam int Q_DEPTH     = 4;
   localparam int OUT_DEPTH   = 8;

   localparam logic REQ_WEIGHT = 1'b0;
   localparam logic REQ_PIXEL  = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [4:0]        weight_index;
      logic signed [15:0] weight_value;
      logic [7:0]        pixel_value;
   } c5rm_req_type;

   typedef struct packed {
      logic [27:0] pooled_value;
      logic [3:0]  pool_row;
      logic [3:0]  pool_col;
      logic        last_of_image;
   } c5rm_rsp_type;

   typedef struct packed {
      logic             cr_odd;
      logic             cc_odd;
      logic [POS_W-1:0] pr;
      logic [POS_W-1:0] pc;
      logic             last;
   } c5rm_meta_type;

   typedef struct packed {
      logic                  is_weight;
      logic [4:0]            tap;
      logic signed [15:0]    weight;
      logic [TAPS-1:0][7:0]  window;
      c5rm_meta_type         meta;
   } c5rm_job_type;

endpackage
`default_nettype wire

// ----- rtl/c5rm_ram.sv -----
`default_nettype none
module c5rm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/c5rm_queue.sv -----
`default_nettype none
module c5rm_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire c5rm_pkg::c5rm_job_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output c5rm_pkg::c5rm_job_type      head,
   output logic                        empty
);

   localparam int AW = $clog2(c5rm_pkg::Q_DEPTH);

   c5rm_pkg::c5rm_job_type slot_ff [c5rm_pkg::Q_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   count_ff, count_in;

   assign full  = (count_ff == (AW+1)'(c5rm_pkg::Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/c5rm_front.sv -----
`default_nettype none
module c5rm_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire c5rm_pkg::c5rm_req_type req_data,
   output logic                        req_full,
   output logic                        q_push,
   output c5rm_pkg::c5rm_job_type      q_data,
   input  wire logic                   q_full
);

   localparam int K  = c5rm_pkg::KERNEL_SIZE;
   localparam int CW = c5rm_pkg::COL_W;
   localparam int PW = c5rm_pkg::POS_W;

   logic [CW-1:0] row_ff, row_in, col_ff, col_in;
   logic          s1_valid_ff, s1_valid_in;
   c5rm_pkg::c5rm_req_type s1_item_ff;
   logic [CW-1:0] s1_row_ff, s1_col_ff;
   logic [K-1:0][K-1:0][7:0] win_ff, win_in;
   logic [K-1:0][7:0] col_new;
   logic [c5rm_pkg::LINE_W-1:0] line_rd, line_wr;
   logic accept, advance, s1_pixel, in_range, tap_ok;
   logic [CW-1:0] cr, cc;
   logic [PW-1:0] pr, pc;

   assign req_full = s1_valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign advance  = s1_valid_ff && !q_full;
   assign s1_pixel = (s1_item_ff.req_type == c5rm_pkg::REQ_PIXEL);

   c5rm_ram #(
      .WIDTH (c5rm_pkg::LINE_W),
      .DEPTH (c5rm_pkg::IMAGE_SIZE)
   ) u_line (
      .clock   (clock),
      .wr_en   (advance && s1_pixel),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_en   (accept && (req_data.req_type == c5rm_pkg::REQ_PIXEL)),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   always_comb begin
      // column of the window: oldest row at index 0, new pixel at the bottom
      col_new[K-1] = s1_item_ff.pixel_value;
      for (int k = 0; k < K-1; k++) begin
         col_new[K-2-k] = line_rd[8*k +: 8];
      end
      line_wr = {line_rd[c5rm_pkg::LINE_W-9:0], s1_item_ff.pixel_value};

      win_in = win_ff;
      if (advance && s1_pixel) begin
         for (int j = 0; j < K-1; j++) begin
            win_in[j] = win_ff[j+1];
         end
         win_in[K-1] = col_new;
      end

      cr = s1_row_ff - CW'(K-1);
      cc = s1_col_ff - CW'(K-1);
      in_range = (s1_row_ff >= CW'(K-1)) && (s1_col_ff >= CW'(K-1)) &&
                 ({1'b0, cr} < (CW+1)'(2*c5rm_pkg::POOL_SIZE)) &&
                 ({1'b0, cc} < (CW+1)'(2*c5rm_pkg::POOL_SIZE));
      pr = PW'(cr >> 1);
      pc = PW'(cc >> 1);
      tap_ok = ({1'b0, s1_item_ff.weight_index} < 6'(c5rm_pkg::TAPS));

      q_data.is_weight   = !s1_pixel;
      q_data.tap         = s1_item_ff.weight_index;
      q_data.weight      = s1_item_ff.weight_value;
      for (int i = 0; i < K; i++) begin
         for (int j = 0; j < K; j++) begin
            q_data.window[i*K+j] = win_in[j][i];
         end
      end
      q_data.meta.cr_odd = cr[0];
      q_data.meta.cc_odd = cc[0];
      q_data.meta.pr     = pr;
      q_data.meta.pc     = pc;
      q_data.meta.last   = (pr == PW'(c5rm_pkg::POOL_SIZE-1)) &&
                           (pc == PW'(c5rm_pkg::POOL_SIZE-1));
      q_push = advance && (s1_pixel ? in_range : tap_ok);

      s1_valid_in = accept || (s1_valid_ff && !advance);
      row_in = row_ff;
      col_in = col_ff;
      if (accept && (req_data.req_type == c5rm_pkg::REQ_PIXEL)) begin
         if (col_ff == CW'(c5rm_pkg::IMAGE_SIZE-1)) begin
            col_in = '0;
            row_in = (row_ff == CW'(c5rm_pkg::IMAGE_SIZE-1)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_item_ff <= req_data;
         s1_row_ff  <= row_ff;
         s1_col_ff  <= col_ff;
      end
      win_ff <= win_in;
   end

endmodule
`default_nettype wire

// ----- rtl/c5rm_back.sv -----
`default_nettype none
module c5rm_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire c5rm_pkg::c5rm_job_type q_head,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   output c5rm_pkg::c5rm_rsp_type      rsp_data,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop
);

   localparam int K    = c5rm_pkg::KERNEL_SIZE;
   localparam int T    = c5rm_pkg::TAPS;
   localparam int PRW  = c5rm_pkg::PROD_W;
   localparam int RW   = c5rm_pkg::ROW_W;
   localparam int SW   = c5rm_pkg::SUM_W;
   localparam int VW   = c5rm_pkg::VALUE_W;
   localparam int OAW  = $clog2(c5rm_pkg::OUT_DEPTH);
   localparam logic signed [SW-1:0] SAT = SW'(c5rm_pkg::VALUE_MAX);

   logic signed [15:0]    weight_ff [T];
   logic signed [PRW-1:0] prod_ff [T];
   logic signed [PRW-1:0] prod_in [T];
   logic signed [RW-1:0]  rsum_ff [K];
   logic signed [RW-1:0]  rsum_in [K];
   logic [VW-1:0]         value_ff, value_in;
   logic signed [SW-1:0]  total;
   logic a_valid_ff, b_valid_ff, c_valid_ff;
   c5rm_pkg::c5rm_meta_type a_meta_ff, b_meta_ff, c_meta_ff;
   logic [VW-1:0] pair_ff, pool_ff [c5rm_pkg::POOL_SIZE];
   logic [VW-1:0] pmax, best;
   logic          out_push;
   c5rm_pkg::c5rm_rsp_type out_item;
   c5rm_pkg::c5rm_rsp_type out_ff [c5rm_pkg::OUT_DEPTH];
   logic [OAW-1:0] owr_ff, ord_ff;
   logic [OAW:0]   ocount_ff, ocount_in;
   logic [OAW:0]   pending;
   logic           take;

   assign pending   = ocount_ff + (OAW+1)'(a_valid_ff) + (OAW+1)'(b_valid_ff) +
                      (OAW+1)'(c_valid_ff);
   // pop only with room reserved for everything still in the pipe
   assign q_pop     = !q_empty && (pending < (OAW+1)'(c5rm_pkg::OUT_DEPTH));
   assign take      = rsp_pop && !rsp_empty;
   assign rsp_empty = (ocount_ff == '0);
   assign rsp_data  = out_ff[ord_ff];

   always_comb begin
      for (int t = 0; t < T; t++) begin
         prod_in[t] = PRW'($signed({1'b0, q_head.window[t]}) * weight_ff[t]);
      end
      for (int i = 0; i < K; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < K; j++) begin
            rsum_in[i] = rsum_in[i] + RW'(prod_ff[i*K+j]);
         end
      end
      total = '0;
      for (int i = 0; i < K; i++) begin
         total = total + SW'(rsum_ff[i]);
      end
      if (total < 0) begin
         value_in = '0;
      end else if (total > SAT) begin
         value_in = VW'(SAT);
      end else begin
         value_in = VW'(total);
      end

      pmax = (value_ff > pair_ff) ? value_ff : pair_ff;
      best = (pool_ff[c_meta_ff.pc] > pmax) ? pool_ff[c_meta_ff.pc] : pmax;
      out_item.pooled_value  = best;
      out_item.pool_row      = 4'(c_meta_ff.pr);
      out_item.pool_col      = 4'(c_meta_ff.pc);
      out_item.last_of_image = c_meta_ff.last;
      out_push  = c_valid_ff && c_meta_ff.cc_odd && c_meta_ff.cr_odd;
      ocount_in = ocount_ff + (OAW+1)'(out_push) - (OAW+1)'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         owr_ff     <= '0;
         ord_ff     <= '0;
         ocount_ff  <= '0;
      end else begin
         a_valid_ff <= q_pop && !q_head.is_weight;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         owr_ff     <= out_push ? owr_ff + 1'b1 : owr_ff;
         ord_ff     <= take ? ord_ff + 1'b1 : ord_ff;
         ocount_ff  <= ocount_in;
      end
      for (int t = 0; t < T; t++) begin
         if (q_pop && q_head.is_weight && (int'(q_head.tap) == t)) begin
            weight_ff[t] <= q_head.weight;
         end
         prod_ff[t] <= prod_in[t];
      end
      for (int i = 0; i < K; i++) begin
         rsum_ff[i] <= rsum_in[i];
      end
      a_meta_ff <= q_head.meta;
      b_meta_ff <= a_meta_ff;
      c_meta_ff <= b_meta_ff;
      value_ff  <= value_in;
      if (c_valid_ff) begin
         if (!c_meta_ff.cc_odd) begin
            pair_ff <= value_ff;
         end else if (!c_meta_ff.cr_odd) begin
            pool_ff[c_meta_ff.pc] <= pmax;
         end
      end
      if (out_push) begin
         out_ff[owr_ff] <= out_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/conv5x5_relu_maxpool2.sv -----
// Channel  | Ports                        | Transaction
// ---------+------------------------------+------------------------------------
// request  | req_push req_full req_data   | weight load or one raster pixel
// response | rsp_empty rsp_pop rsp_data   | one pooled value with position
//
// One item is taken per cycle while req_full is low; the front stage, a 4-entry
// job queue and a three-stage multiply, row-sum, total pipeline carry each
// pooled value to the response ports through the result queue.
// Reset is synchronous and clears the raster position and all queues.
// A stalled response side fills the 8-entry result queue, then the job queue,
// and then raises req_full; no item is lost.
`default_nettype none
module conv5x5_relu_maxpool2 (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire c5rm_pkg::c5rm_req_type req_data,
   output logic                        req_full,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output c5rm_pkg::c5rm_rsp_type      rsp_data
);

   logic q_push, q_full, q_pop, q_empty;
   c5rm_pkg::c5rm_job_type q_in, q_head;

   c5rm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (q_in),
      .q_full   (q_full)
   );

   c5rm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   c5rm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full)) else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty)) else $error("job popped from empty queue");
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last_of_image) |->
         (rsp_data.pool_row == rsp_data.pool_col))
      else $error("last flag off the final corner");
`endif

endmodule
`default_nettype wire
